// ----- hw/rtl/gwvd_pkg.sv -----
// gwvd_pkg: shared types, constants and functions for the gerstner wave unit
// no dependencies
package gwvd_pkg;

  localparam int NUM_WAVES        = 3;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int NUM_WAVE_REGS    = 3;
  localparam int ACC_W            = 64;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [34:0] TWO_PI_Q16  = 35'd411775;

  typedef enum logic [1:0] {
    REG_WAVE0 = 2'd0,
    REG_WAVE1 = 2'd1,
    REG_WAVE2 = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0]      rx;
    logic signed [15:0]      ry;
    logic signed [15:0]      rz;
    logic                    fe;
    logic [31:0]             fc;
    logic signed [ACC_W-1:0] spx;
    logic signed [ACC_W-1:0] spy;
    logic signed [ACC_W-1:0] spz;
    logic signed [ACC_W-1:0] snx;
    logic signed [ACC_W-1:0] sny;
    logic signed [ACC_W-1:0] snz;
  } vtx_t;

  // quarter-period sine entry, q2.30 taylor series rounded to q1.15
  function automatic logic [15:0] sine_entry(input int idx, input int lg);
    logic [63:0] x, x2, t, s, r;
    x  = (HALF_PI_Q30 * 64'(idx)) >> lg;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/gerstner_wave_vertex_displace_unit.sv -----
// gerstner_wave_vertex_displace_unit: top level, wave registers, frame counter,
// chain of wave cells and the output register; depends on gwvd_pkg, gwvd_cell
// four stages per wave cell
// throughput one vertex per cycle, the whole chain advances when the output is free
// reset clears the wave registers, the frame counter and all valid bits
// the sine table is a constant table, no fill after reset
module gerstner_wave_vertex_displace_unit #(
  parameter int NumWaves  = gwvd_pkg::NUM_WAVES,
  parameter int SineDepth = gwvd_pkg::SINE_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        vtx_valid,
  output logic        vtx_stall,
  input  logic [15:0] rest_x,
  input  logic [15:0] rest_y,
  input  logic [15:0] rest_z,
  input  logic        frame_end,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] pos_z,
  output logic [15:0] norm_x,
  output logic [15:0] norm_y,
  output logic [15:0] norm_z,
  output logic        frame_end_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import gwvd_pkg::*;

  logic [63:0] wave_regs [NUM_WAVE_REGS];
  logic [31:0] frame_count;
  logic        adv;
  logic        chain_vld [NumWaves+1];
  vtx_t        chain_vtx [NumWaves+1];
  vtx_t        last;
  logic        org;

  assign cfg_ready = 1'b1;
  assign adv       = !(res_valid && res_stall);
  assign vtx_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WAVE_REGS; i++) begin
        wave_regs[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_WAVE0: wave_regs[0] <= cfg_data;
        REG_WAVE1: wave_regs[1] <= cfg_data;
        REG_WAVE2: wave_regs[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (vtx_valid && adv && frame_end) begin
      frame_count <= frame_count + 32'd1;
    end
  end

  always_comb begin
    chain_vld[0]     = vtx_valid;
    chain_vtx[0]     = '0;
    chain_vtx[0].rx  = rest_x;
    chain_vtx[0].ry  = rest_y;
    chain_vtx[0].rz  = rest_z;
    chain_vtx[0].fe  = frame_end;
    chain_vtx[0].fc  = frame_count;
  end

  for (genvar g = 0; g < NumWaves; g++) begin : g_cell
    logic [63:0] prm;
    if (g < NUM_WAVE_REGS) begin : g_reg
      assign prm = wave_regs[g];
    end else begin : g_zero
      assign prm = '0;
    end
    gwvd_cell #(
      .WaveIdx  (g),
      .SineDepth(SineDepth)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .prm    (prm),
      .vld_in (chain_vld[g]),
      .vtx_in (chain_vtx[g]),
      .vld_out(chain_vld[g+1]),
      .vtx_out(chain_vtx[g+1])
    );
  end

  assign last = chain_vtx[NumWaves];
  assign org  = (last.rx == 16'sd0) && (last.ry == 16'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= chain_vld[NumWaves];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_end_out <= last.fe;
      if (org) begin
        pos_x  <= last.rx;
        pos_y  <= last.ry;
        pos_z  <= last.rz;
        norm_x <= '0;
        norm_y <= '0;
        norm_z <= '0;
      end else begin
        pos_x  <= sat16(ACC_W'(last.rx) + ((last.spx + (64'sd1 <<< 30)) >>> 31));
        pos_y  <= sat16(ACC_W'(last.ry) + ((last.spy + (64'sd1 <<< 30)) >>> 31));
        pos_z  <= sat16(ACC_W'(last.rz) + ((last.spz + (64'sd1 <<< 14)) >>> 15));
        norm_x <= sat16(-((last.snx + (64'sd1 <<< 26)) >>> 27));
        norm_y <= sat16(-((last.sny + (64'sd1 <<< 26)) >>> 27));
        norm_z <= sat16(64'sd256 - ((last.snz + (64'sd1 <<< 26)) >>> 27));
      end
    end
  end

endmodule

// ----- hw/rtl/gwvd_cell.sv -----
// gwvd_cell: one wave of the chain, four stages, adds its terms to the running sums
// depends on gwvd_pkg
module gwvd_cell #(
  parameter int WaveIdx   = 0,
  parameter int SineDepth = gwvd_pkg::SINE_TABLE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [63:0]    prm,
  input  logic           vld_in,
  input  gwvd_pkg::vtx_t vtx_in,
  output logic           vld_out,
  output gwvd_pkg::vtx_t vtx_out
);
  import gwvd_pkg::*;

  localparam int IdxW = $clog2(SineDepth);
  localparam bit DirX = (WaveIdx % 3) != 1;
  localparam bit DirY = (WaveIdx % 3) != 0;

  typedef logic [15:0] tbl_t [SineDepth];

  function automatic tbl_t build_tbl();
    tbl_t r;
    for (int i = 0; i < SineDepth; i++) begin
      r[i] = sine_entry(i, IdxW);
    end
    return r;
  endfunction

  localparam tbl_t SINE_TBL = build_tbl();

  function automatic logic signed [15:0] sine_of(input logic [31:0] ph);
    logic [IdxW-1:0]    idx;
    logic signed [15:0] v;
    idx = ph[29 -: IdxW];
    if (ph[30]) begin
      if (idx == '0) begin
        v = 16'sh7fff;
      end else begin
        v = SINE_TBL[IdxW'(~idx + 1'b1)];
      end
    end else begin
      v = SINE_TBL[idx];
    end
    return ph[31] ? -v : v;
  endfunction

  logic signed [15:0] amp;
  logic [15:0]        stp, frq, rate;
  logic signed [17:0] d;

  assign amp  = prm[15:0];
  assign stp  = prm[31:16];
  assign frq  = prm[47:32];
  assign rate = prm[63:48];
  assign d    = (DirX ? 18'(vtx_in.rx) : 18'sd0) + (DirY ? 18'(vtx_in.ry) : 18'sd0);

  // stage 1
  logic               vld1;
  vtx_t               v1;
  logic [19:0]        sp1;
  logic [15:0]        tm1, stp1;
  logic [18:0]        k1;
  logic signed [32:0] qa1;
  logic signed [15:0] amp1;
  logic signed [34:0] spm;
  logic [31:0]        tmm;
  logic [34:0]        km;

  assign spm = $signed({19'b0, frq}) * 35'(d);
  assign tmm = {16'b0, rate} * {16'b0, vtx_in.fc[15:0]};
  assign km  = ({19'b0, frq} * TWO_PI_Q16) + 35'd32768;

  // stage 2
  logic               vld2;
  vtx_t               v2;
  logic [31:0]        ph2;
  logic [15:0]        stp2;
  logic signed [35:0] ka2;
  logic signed [32:0] qa2;
  logic signed [15:0] amp2;

  // stage 3
  logic               vld3;
  vtx_t               v3;
  logic signed [15:0] s3, c3, amp3;
  logic signed [36:0] qk3;
  logic signed [35:0] ka3;
  logic signed [32:0] qa3;
  logic signed [52:0] qkm;

  assign qkm = $signed({37'b0, stp2}) * 53'(ka2) + 53'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld1    <= vld_in;
      vld2    <= vld1;
      vld3    <= vld2;
      vld_out <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1   <= vtx_in;
      sp1  <= spm[19:0];
      tm1  <= tmm[15:0];
      k1   <= km[34:16];
      qa1  <= $signed({17'b0, stp}) * 33'(amp);
      amp1 <= amp;
      stp1 <= stp;

      v2   <= v1;
      ph2  <= {sp1, 12'b0} + {tm1, 16'b0};
      ka2  <= $signed({17'b0, k1}) * 36'(amp1);
      qa2  <= qa1;
      amp2 <= amp1;
      stp2 <= stp1;

      v3   <= v2;
      s3   <= sine_of(ph2);
      c3   <= sine_of(ph2 + 32'h4000_0000);
      qk3  <= qkm[52:16];
      ka3  <= ka2;
      qa3  <= qa2;
      amp3 <= amp2;

      vtx_out.rx  <= v3.rx;
      vtx_out.ry  <= v3.ry;
      vtx_out.rz  <= v3.rz;
      vtx_out.fe  <= v3.fe;
      vtx_out.fc  <= v3.fc;
      vtx_out.spx <= v3.spx + (DirX ? ACC_W'(qa3 * 50'(c3)) : '0);
      vtx_out.spy <= v3.spy + (DirY ? ACC_W'(qa3 * 50'(c3)) : '0);
      vtx_out.spz <= v3.spz + ACC_W'(amp3 * 32'(s3));
      vtx_out.snx <= v3.snx + (DirX ? ACC_W'(ka3 * 53'(c3)) : '0);
      vtx_out.sny <= v3.sny + (DirY ? ACC_W'(ka3 * 53'(c3)) : '0);
      vtx_out.snz <= v3.snz + ACC_W'(qk3 * 54'(s3));
    end
  end

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for gerstner_wave_vertex_displace_unit
// drives vertex transactions, predicts displaced positions and normals, checks them
// depends on gwvd_pkg and the unit rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gwvd_pkg::*;

  localparam int DEPTH = 1024;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [15:0] px, py, pz, nx, ny, nz;
    logic        fe;
  } vtx_out_t;

  logic clk = 0, rst = 1;
  logic vtx_valid = 0, vtx_stall;
  logic [15:0] rest_x = 0, rest_y = 0, rest_z = 0;
  logic frame_end = 0;
  logic res_valid, res_stall = 0;
  logic [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
  logic frame_end_out;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = REG_WAVE0;
  logic [63:0] cfg_data = 0;

  gerstner_wave_vertex_displace_unit u_dut (.*);

  logic [63:0] wave_reg [3];
  logic [31:0] frame_cnt;
  logic [15:0] quarter_sine [DEPTH];
  vtx_out_t    expected_q [$];
  int          errors = 0, checked = 0, sent = 0;
  int          send_idle_pct = 0, stall_pct = 0;
  int          hold_off = 0;
  longint      cycles = 0;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // q2.30 taylor build of the quarter sine table
  initial begin
    longint unsigned x, x2, t, s, r;
    longint unsigned dv [5] = '{110, 72, 42, 20, 6};
    for (int i = 0; i < DEPTH; i++) begin
      x = (64'd1686629713 * i) / DEPTH;
      x2 = (x * x) >> 30;
      t = 64'd1073741824;
      for (int j = 0; j < 5; j++) t = 64'd1073741824 - ((x2 * t) >> 30) / dv[j];
      s = (x * t) >> 30;
      r = (s + 16384) >> 15;
      if (r > 32767) r = 32767;
      quarter_sine[i] = r[15:0];
    end
  end

  function automatic longint sine_lookup(logic [31:0] ph);
    longint unsigned f;
    int idx, k;
    longint v;
    f = ph[29:0];
    idx = int'((f * DEPTH) >> 30);
    k = ph[30] ? DEPTH - idx : idx;
    v = (k >= DEPTH) ? 32767 : longint'(quarter_sine[k]);
    return ph[31] ? -v : v;
  endfunction

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic vtx_out_t displace_vertex(logic [15:0] x, logic [15:0] y,
                                               logic [15:0] z, logic fe);
    vtx_out_t o;
    longint rx, ry, rz, amp, stp, frq, rate, ddx, ddy, d, s, c, qa, k, ka, qk;
    longint spx, spy, spz, snx, sny, snz;
    logic [31:0] ph;
    rx = longint'($signed(x)); ry = longint'($signed(y)); rz = longint'($signed(z));
    o.px = x; o.py = y; o.pz = z; o.nx = 0; o.ny = 0; o.nz = 0; o.fe = fe;
    if (!(rx == 0 && ry == 0)) begin
      spx = 0; spy = 0; spz = 0; snx = 0; sny = 0; snz = 0;
      for (int i = 0; i < 3; i++) begin
        amp = longint'($signed(wave_reg[i][15:0]));
        stp = longint'(wave_reg[i][31:16]);
        frq = longint'(wave_reg[i][47:32]);
        rate = longint'(wave_reg[i][63:48]);
        ddx = (i == 1) ? 0 : 1;
        ddy = (i == 0) ? 0 : 1;
        d = ddx * rx + ddy * ry;
        ph = 32'((frq * d) << 12) + 32'((rate * longint'(frame_cnt)) << 16);
        s = sine_lookup(ph);
        c = sine_lookup(ph + 32'h4000_0000);
        qa = stp * amp;
        k = (frq * 411775 + 32768) >>> 16;
        ka = k * amp;
        qk = rnd_shift(stp * ka, 16);
        spx += qa * ddx * c; spy += qa * ddy * c; spz += amp * s;
        snx += ka * ddx * c; sny += ka * ddy * c; snz += qk * s;
      end
      o.px = 16'(clamp16(rx + rnd_shift(spx, 31)));
      o.py = 16'(clamp16(ry + rnd_shift(spy, 31)));
      o.pz = 16'(clamp16(rz + rnd_shift(spz, 15)));
      o.nx = 16'(clamp16(-rnd_shift(snx, 27)));
      o.ny = 16'(clamp16(-rnd_shift(sny, 27)));
      o.nz = 16'(clamp16(256 - rnd_shift(snz, 27)));
    end
    if (fe) frame_cnt = frame_cnt + 1;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h at result %0d", what, got, want, checked);
    errors++;
  endtask

  // output side: stall control and result check
  always @(posedge clk) begin
    vtx_out_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result transaction");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
        if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
        if (pos_z !== e.pz) report_mismatch("pos_z", pos_z, e.pz);
        if (norm_x !== e.nx) report_mismatch("norm_x", norm_x, e.nx);
        if (norm_y !== e.ny) report_mismatch("norm_y", norm_y, e.ny);
        if (norm_z !== e.nz) report_mismatch("norm_z", norm_z, e.nz);
        if (frame_end_out !== e.fe) report_mismatch("frame_end_out", 16'(frame_end_out),
                                                    16'(e.fe));
      end
      checked++;
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_stall <= 1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_valid <= 0;
      @(posedge clk);
    end
    vtx_valid <= 1;
    rest_x <= x; rest_y <= y; rest_z <= z; frame_end <= fe;
    do @(posedge clk); while (vtx_stall);
    expected_q.insert(expected_q.size(), displace_vertex(x, y, z, fe));
    sent++;
  endtask

  task automatic drain();
    vtx_valid <= 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_wave(logic [1:0] idx, logic [63:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_WAVE2) wave_reg[idx] = data;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] wave_word(bit wild);
    if (wild) return {$urandom, $urandom};
    return {16'($urandom_range(2000)), 16'($urandom_range(4095)),
            16'($urandom_range(40000)), 16'($urandom_range(1500) - 750)};
  endfunction

  task automatic random_vertices(int n);
    for (int i = 0; i < n; i++)
      send_vertex(16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(15) == 0);
  endtask

  task automatic test_reset_defaults();
    send_vertex(16'h0100, 16'h0000, 16'h1234, 0);
    send_vertex(16'h0000, 16'h0000, 16'h8000, 1);
    drain();
  endtask

  task automatic test_directed();
    logic [15:0] ext [6] = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff, 16'h0100};
    write_wave(REG_WAVE0, 64'h0100_1000_2000_0200);
    write_wave(REG_WAVE1, 64'h0080_ffff_1000_ff00);
    write_wave(REG_WAVE2, 64'hffff_8000_ffff_7fff);
    write_wave(REG_NONE, 64'hdead_beef_dead_beef);
    for (int i = 0; i < 6; i++) send_vertex(ext[i], ext[5 - i], ext[i], i[0]);
    send_vertex(16'h0000, 16'h0000, 16'h7fff, 0);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 1);
    send_vertex(16'h0040, 16'h0000, 16'h0000, 0);
    send_vertex(16'h0000, 16'h0040, 16'h0000, 0);
    drain();
    write_wave(REG_WAVE0, 64'hffff_ffff_ffff_ffff);
    write_wave(REG_WAVE1, 64'hffff_ffff_ffff_8000);
    write_wave(REG_WAVE2, 64'hffff_ffff_ffff_7fff);
    for (int i = 0; i < 6; i++) send_vertex(ext[i], ext[(i + 2) % 6], ext[5 - i], 1);
    drain();
  endtask

  task automatic test_idle_phases();
    int sp [4] = '{0, 46, 0, 33};
    int rp [4] = '{0, 0, 46, 33};
    for (int p = 0; p < 4; p++) begin
      write_wave(REG_WAVE0, wave_word(p == 3));
      write_wave(REG_WAVE1, wave_word(0));
      write_wave(REG_WAVE2, wave_word(p == 1));
      send_idle_pct = sp[p]; stall_pct = rp[p];
      random_vertices(200);
      drain();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; stall_pct = 0;
    write_wave(REG_WAVE0, wave_word(0));
    hold_off = 60;
    random_vertices(80);
    drain();
    send_idle_pct = 20; stall_pct = 20;
    random_vertices(60);
    drain();
    random_vertices(60);
    drain();
    send_idle_pct = 0; stall_pct = 0;
    write_wave(REG_WAVE1, 64'h0);
    write_wave(REG_WAVE2, 64'h0);
    write_wave(REG_WAVE0, 64'h0);
    random_vertices(20);
    drain();
  endtask

  initial begin
    frame_cnt = 0;
    for (int i = 0; i < 3; i++) wave_reg[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_idle_phases();
    test_backpressure();
    $display("covered %0d vertices, %0d results, %0d frames, reg extremes and stalls",
             sent, checked, frame_cnt);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
